// ===== rtl/tls_pkg.sv =====
package tls_pkg;

  localparam int UNIT_W    = 32;
  localparam int REG_IDX_W = 2;
  localparam int CFG_W     = 32;
  localparam int Q_DEPTH   = 4;
  localparam int Q_PTR_W   = 2;
  localparam int Q_CNT_W   = 3;

  localparam logic [7:0] CR_CODE = 8'd13;
  localparam logic [7:0] LF_CODE = 8'd10;

  localparam logic [REG_IDX_W-1:0] REG_CHAR_BYTES = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_BIG_ENDIAN = 2'd1;

  typedef struct packed {
    logic [UNIT_W-1:0] out_char;
    logic              line_last;
  } result_t;

endpackage

// ===== rtl/tls_item_if.sv =====
interface tls_item_if;
  import tls_pkg::*;

  logic              valid;
  logic              ready;
  logic              kind;
  logic [UNIT_W-1:0] char_value;

  modport source (output valid, output kind, output char_value, input ready);
  modport sink   (input valid, input kind, input char_value, output ready);
endinterface

// ===== rtl/tls_res_if.sv =====
interface tls_res_if;
  import tls_pkg::*;

  logic              valid;
  logic              ready;
  logic [UNIT_W-1:0] out_char;
  logic              line_last;

  modport source (output valid, output out_char, output line_last, input ready);
  modport sink   (input valid, input out_char, input line_last, output ready);
endinterface

// ===== rtl/tls_cfg_if.sv =====
interface tls_cfg_if;
  import tls_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [REG_IDX_W-1:0] reg_idx;
  logic [CFG_W-1:0]     data;

  modport source (output valid, output reg_idx, output data, input ready);
  modport sink   (input valid, input reg_idx, input data, output ready);
endinterface

// ===== rtl/text_line_splitter.sv =====
// channel   dir   payload                    handshake
// in_ch     in    kind, char_value[31:0]     valid/ready
// out_ch    out   out_char[31:0], line_last  valid/ready
// cfg_ch    in    reg_idx[1:0], data[31:0]   valid/ready, ready always high
//
// One item per cycle: each accepted item is decided in the cycle it is taken
// and its 0..2 results are pushed into a 4-entry result queue.
// in_ready drops while the queue holds 3 or 4 results; out_ch drains one
// result per cycle while out_ch.ready is high, so items that make two results each run at half rate.
// Synchronous active-low reset empties the queue and the line-ending hold, sets char_bytes to 1 and clears big_endian.
module text_line_splitter #(
  parameter int CHAR_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  tls_item_if.sink   in_ch,
  tls_res_if.source  out_ch,
  tls_cfg_if.sink    cfg_ch
);
  import tls_pkg::*;

  typedef enum logic [1:0] {PH_NONE, PH_CR, PH_CRCR, PH_LF_HELD} phase_t;

  // config
  logic [2:0] char_bytes_r;
  logic       big_endian_r;

  // line-ending hold
  phase_t                phase_r, phase_nxt;
  logic [1:0]            held_cnt_r, held_cnt_nxt;
  logic [CHAR_WIDTH-1:0] held0_r, held0_nxt;
  logic [CHAR_WIDTH-1:0] held1_r, held1_nxt;

  // result queue
  result_t              q_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0]   q_cnt_r;

  logic                  in_fire, out_fire;
  logic [2:0]            unit_bytes;
  logic [5:0]            unit_bits;
  logic [4:0]            be_shift;
  logic [CHAR_WIDTH-1:0] unit_mask;
  logic [CHAR_WIDTH-1:0] c_w;
  logic [UNIT_W-1:0]     c32, cr32, lf32;
  logic                  is_cr, is_lf;
  logic [1:0]            res_n;
  result_t               res0, res1;
  logic                  fresh_emit, fresh_last;

  assign in_fire  = in_ch.valid & in_ch.ready;
  assign out_fire = out_ch.valid & out_ch.ready;

  assign in_ch.ready  = (q_cnt_r <= Q_CNT_W'(Q_DEPTH - 2));
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid     = (q_cnt_r != '0);
  assign out_ch.out_char  = q_r[rd_ptr_r].out_char;
  assign out_ch.line_last = q_r[rd_ptr_r].line_last;

  // 0 acts as 1, 5..7 act as 4
  always_comb begin
    case (char_bytes_r)
      3'd0:    unit_bytes = 3'd1;
      3'd1,
      3'd2,
      3'd3,
      3'd4:    unit_bytes = char_bytes_r;
      default: unit_bytes = 3'd4;
    endcase
  end

  assign unit_bits = {unit_bytes, 3'b000};
  // shift past the unit width yields zero, i.e. a full mask
  assign unit_mask = ~({CHAR_WIDTH{1'b1}} << unit_bits);
  assign c_w       = in_ch.char_value[CHAR_WIDTH-1:0] & unit_mask;
  assign c32       = UNIT_W'(c_w);
  assign be_shift  = big_endian_r ? {unit_bytes[1:0] - 2'd1, 3'b000} : 5'd0;
  assign cr32      = UNIT_W'(CR_CODE) << be_shift;
  assign lf32      = UNIT_W'(LF_CODE) << be_shift;
  assign is_cr     = (c32 == cr32);
  assign is_lf     = (c32 == lf32);

  always_comb begin
    phase_nxt    = phase_r;
    held_cnt_nxt = held_cnt_r;
    held0_nxt    = held0_r;
    held1_nxt    = held1_r;
    res_n        = 2'd0;
    res0         = '0;
    res1         = '0;
    fresh_emit   = 1'b0;
    fresh_last   = 1'b0;

    if (in_ch.kind) begin
      // end of data: flush the hold
      case (phase_r)
        PH_NONE: begin
          if (held_cnt_r != 2'd0) begin
            res0  = '{UNIT_W'(held0_r), 1'b0};
            res_n = 2'd1;
          end
        end
        PH_CR, PH_LF_HELD: begin
          res0  = '{UNIT_W'(held0_r), 1'b1};
          res_n = 2'd1;
        end
        PH_CRCR: begin
          res0  = '{UNIT_W'(held0_r), 1'b1};
          res1  = '{UNIT_W'(held1_r), 1'b1};
          res_n = 2'd2;
        end
        default: ;
      endcase
      phase_nxt    = PH_NONE;
      held_cnt_nxt = 2'd0;
    end else begin
      case (phase_r)
        PH_NONE, PH_LF_HELD: begin
          phase_nxt    = PH_NONE;
          held_cnt_nxt = 2'd0;
          if (is_lf) begin
            fresh_emit = 1'b1;
            fresh_last = 1'b1;
          end else if (is_cr) begin
            held0_nxt    = c_w;
            held_cnt_nxt = 2'd1;
            phase_nxt    = PH_CR;
          end else begin
            fresh_emit = 1'b1;
          end
          if (held_cnt_r != 2'd0) begin
            res0  = '{UNIT_W'(held0_r), phase_r == PH_LF_HELD};
            res1  = '{c32, fresh_last};
            res_n = fresh_emit ? 2'd2 : 2'd1;
          end else begin
            res0  = '{c32, fresh_last};
            res_n = fresh_emit ? 2'd1 : 2'd0;
          end
        end
        PH_CR: begin
          if (is_cr) begin
            held1_nxt    = c_w;
            held_cnt_nxt = 2'd2;
            phase_nxt    = PH_CRCR;
          end else begin
            // CR LF closes one line; CR x ends at the CR
            res0         = '{UNIT_W'(held0_r), !is_lf};
            res1         = '{c32, is_lf};
            res_n        = 2'd2;
            held_cnt_nxt = 2'd0;
            phase_nxt    = PH_NONE;
          end
        end
        PH_CRCR: begin
          // the new unit is held one step behind the two CRs
          res0         = '{UNIT_W'(held0_r), !is_lf};
          res1         = '{UNIT_W'(held1_r), !is_lf};
          res_n        = 2'd2;
          held0_nxt    = c_w;
          held_cnt_nxt = 2'd1;
          phase_nxt    = is_lf ? PH_LF_HELD : (is_cr ? PH_CR : PH_NONE);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      char_bytes_r <= 3'd1;
      big_endian_r <= 1'b0;
      phase_r      <= PH_NONE;
      held_cnt_r   <= 2'd0;
      wr_ptr_r     <= '0;
      rd_ptr_r     <= '0;
      q_cnt_r      <= '0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.reg_idx)
          REG_CHAR_BYTES: char_bytes_r <= cfg_ch.data[2:0];
          REG_BIG_ENDIAN: big_endian_r <= cfg_ch.data[0];
          default: ;
        endcase
      end

      if (in_fire) begin
        phase_r    <= phase_nxt;
        held_cnt_r <= held_cnt_nxt;
        held0_r    <= held0_nxt;
        held1_r    <= held1_nxt;
        if (res_n != 2'd0) begin
          q_r[wr_ptr_r] <= res0;
        end
        if (res_n == 2'd2) begin
          q_r[wr_ptr_r + Q_PTR_W'(1)] <= res1;
        end
        wr_ptr_r <= wr_ptr_r + Q_PTR_W'(res_n);
      end

      if (out_fire) begin
        rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      end

      q_cnt_r <= q_cnt_r + (in_fire ? Q_CNT_W'(res_n) : '0) - Q_CNT_W'(out_fire);
    end
  end

endmodule

// ===== rtl/tls_checker.sv =====
module tls_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [tls_pkg::UNIT_W-1:0] out_char,
  input logic                  out_line_last
);
  import tls_pkg::*;

  // queue comes up empty after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending right after reset");

  // input only stalls when results are waiting
  a_stall_has_results: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no result queued");

  a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_char) && $stable(out_line_last))
    else $error("result changed while stalled");

endmodule

bind text_line_splitter tls_checker u_tls_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_char      (out_ch.out_char),
  .out_line_last (out_ch.line_last)
);

// ===== sim/text_line_splitter_tb.sv =====
module text_line_splitter_tb;
  import tls_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 300000;
  localparam int SETTLE_CYC  = 8;
  localparam int N_PHASE     = 11;
  localparam int PHASE_ITEMS = 93;
  localparam int MAX_PRINTS  = 200;

  localparam logic [REG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

  // char_bytes / big_endian per random phase; odd widths included
  localparam logic [2:0] PH_CB [N_PHASE] = '{3'd1, 3'd4, 3'd2, 3'd4, 3'd2, 3'd1,
                                              3'd3, 3'd0, 3'd7, 3'd5, 3'd6};
  localparam logic       PH_BE [N_PHASE] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1,
                                              1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

  typedef enum logic [1:0] {EOL_NONE, EOL_CR, EOL_CRCR, EOL_LF_HELD} eol_e;
  typedef enum {ROW_CHAR, ROW_FLUSH, ROW_CFG} row_op_e;

  // n < 0: expectation comes from the line predictor
  typedef struct {
    row_op_e              op;
    logic [UNIT_W-1:0]    val;
    logic [REG_IDX_W-1:0] idx;
    int                   n;
    logic [UNIT_W-1:0]    c0;
    logic                 l0;
    logic [UNIT_W-1:0]    c1;
    logic                 l1;
  } row_t;

  localparam int DIR_N = 36;
  row_t dir_tab [DIR_N] = '{
    '{ROW_FLUSH, 32'h0000_0000, REG_CHAR_BYTES,  0, 32'h00, 1'b0, 32'h00, 1'b0},
    '{ROW_CHAR,  32'h0000_0041, REG_CHAR_BYTES,  1, 32'h41, 1'b0, 32'h00, 1'b0},
    '{ROW_CHAR,  32'hFFFF_FFFF, REG_CHAR_BYTES,  1, 32'hFF, 1'b0, 32'h00, 1'b0},
    '{ROW_CHAR,  32'hFFFF_FF0A, REG_CHAR_BYTES,  1, 32'h0A, 1'b1, 32'h00, 1'b0},
    '{ROW_CHAR,  32'h0000_000D, REG_CHAR_BYTES,  0, 32'h00, 1'b0, 32'h00, 1'b0},
    '{ROW_CHAR,  32'h0000_000A, REG_CHAR_BYTES,  2, 32'h0D, 1'b0, 32'h0A, 1'b1},
    '{ROW_CHAR,  32'h0000_000D, REG_CHAR_BYTES,  0, 32'h00, 1'b0, 32'h00, 1'b0},
    '{ROW_CHAR,  32'h0000_000D, REG_CHAR_BYTES,  0, 32'h00, 1'b0, 32'h00, 1'b0},
    '{ROW_CHAR,  32'h0000_000A, REG_CHAR_BYTES,  2, 32'h0D, 1'b0, 32'h0D, 1'b0},
    '{ROW_CHAR,  32'h0000_0042, REG_CHAR_BYTES,  2, 32'h0A, 1'b1, 32'h42, 1'b0},
    '{ROW_CHAR,  32'h0000_000D, REG_CHAR_BYTES,  0, 32'h00, 1'b0, 32'h00, 1'b0},
    '{ROW_CHAR,  32'h0000_000D, REG_CHAR_BYTES,  0, 32'h00, 1'b0, 32'h00, 1'b0},
    '{ROW_CHAR,  32'h0000_0043, REG_CHAR_BYTES,  2, 32'h0D, 1'b1, 32'h0D, 1'b1},
    '{ROW_FLUSH, 32'h0000_0000, REG_CHAR_BYTES,  1, 32'h43, 1'b0, 32'h00, 1'b0},
    '{ROW_CHAR,  32'h0000_000D, REG_CHAR_BYTES,  0, 32'h00, 1'b0, 32'h00, 1'b0},
    '{ROW_CHAR,  32'h0000_000D, REG_CHAR_BYTES,  0, 32'h00, 1'b0, 32'h00, 1'b0},
    '{ROW_CHAR,  32'hFFFF_FF0D, REG_CHAR_BYTES,  2, 32'h0D, 1'b1, 32'h0D, 1'b1},
    '{ROW_FLUSH, 32'hFFFF_FFFF, REG_CHAR_BYTES,  1, 32'h0D, 1'b1, 32'h00, 1'b0},
    '{ROW_CHAR,  32'h0000_000D, REG_CHAR_BYTES,  0, 32'h00, 1'b0, 32'h00, 1'b0},
    '{ROW_CHAR,  32'h0000_000D, REG_CHAR_BYTES,  0, 32'h00, 1'b0, 32'h00, 1'b0},
    '{ROW_FLUSH, 32'h0000_0000, REG_CHAR_BYTES,  2, 32'h0D, 1'b1, 32'h0D, 1'b1},
    '{ROW_CHAR,  32'h0000_000D, REG_CHAR_BYTES,  0, 32'h00, 1'b0, 32'h00, 1'b0},
    '{ROW_CHAR,  32'h0000_000D, REG_CHAR_BYTES,  0, 32'h00, 1'b0, 32'h00, 1'b0},
    '{ROW_CHAR,  32'h0000_000A, REG_CHAR_BYTES,  2, 32'h0D, 1'b0, 32'h0D, 1'b0},
    '{ROW_FLUSH, 32'h0000_0000, REG_CHAR_BYTES,  1, 32'h0A, 1'b1, 32'h00, 1'b0},
    '{ROW_CFG,   32'h0000_0004, REG_CHAR_BYTES, -1, 32'h00, 1'b0, 32'h00, 1'b0},
    '{ROW_CFG,   32'h0000_0001, REG_BIG_ENDIAN, -1, 32'h00, 1'b0, 32'h00, 1'b0},
    '{ROW_CHAR,  32'h0D00_0000, REG_CHAR_BYTES, -1, 32'h00, 1'b0, 32'h00, 1'b0},
    '{ROW_CHAR,  32'h0D00_0000, REG_CHAR_BYTES, -1, 32'h00, 1'b0, 32'h00, 1'b0},
    '{ROW_CHAR,  32'h0A00_0000, REG_CHAR_BYTES, -1, 32'h00, 1'b0, 32'h00, 1'b0},
    '{ROW_FLUSH, 32'h0000_0000, REG_CHAR_BYTES, -1, 32'h00, 1'b0, 32'h00, 1'b0},
    '{ROW_CFG,   32'h0000_0002, REG_CHAR_BYTES, -1, 32'h00, 1'b0, 32'h00, 1'b0},
    '{ROW_CHAR,  32'hFFFF_0D00, REG_CHAR_BYTES, -1, 32'h00, 1'b0, 32'h00, 1'b0},
    '{ROW_FLUSH, 32'h0000_0000, REG_CHAR_BYTES, -1, 32'h00, 1'b0, 32'h00, 1'b0},
    '{ROW_CFG,   32'h0000_0001, REG_CHAR_BYTES, -1, 32'h00, 1'b0, 32'h00, 1'b0},
    '{ROW_CFG,   32'h0000_0000, REG_BIG_ENDIAN, -1, 32'h00, 1'b0, 32'h00, 1'b0}
  };

  logic clk;
  logic rst_n;

  tls_item_if in_ch ();
  tls_res_if  out_ch ();
  tls_cfg_if  cfg_ch ();

  text_line_splitter dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // line splitter state as the block should hold it
  logic [2:0]        cb_reg   = 3'd1;
  logic              be_reg   = 1'b0;
  eol_e              eol      = EOL_NONE;
  logic [UNIT_W-1:0] held [2] = '{32'h0, 32'h0};
  logic [1:0]        held_n   = 2'd0;

  result_t step_q [$];
  result_t line_q [$];   // results still owed by the block, oldest first
  result_t typed_q [$];
  bit      use_typed = 1'b0;

  int          err_cnt  = 0;
  int          cyc      = 0;
  int unsigned gap_max  = 0;
  int unsigned recv_max = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic report(input string msg);
    if (err_cnt < MAX_PRINTS)
      $display("MISMATCH @%0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  function automatic int unsigned unit_bytes();
    int unsigned b;
    b = cb_reg;
    if (b == 0) b = 1;
    if (b > 4) b = 4;
    return b;
  endfunction

  function automatic logic [UNIT_W-1:0] unit_mask();
    int unsigned nb;
    nb = unit_bytes();
    if (nb >= 4) return '1;
    return (32'd1 << (nb * 8)) - 32'd1;
  endfunction

  function automatic int unsigned eol_shift();
    return be_reg ? (unit_bytes() - 1) * 8 : 0;
  endfunction

  function automatic void put_char(input logic [UNIT_W-1:0] c, input logic last);
    result_t r;
    r.out_char  = c;
    r.line_last = last;
    step_q.push_back(r);
  endfunction

  function automatic void take_fresh(input logic [UNIT_W-1:0] c, input bit is_cr,
                                     input bit is_lf);
    if (is_lf) begin
      put_char(c, 1'b1);
    end else if (is_cr) begin
      held[0] = c;
      held_n  = 2'd1;
      eol     = EOL_CR;
    end else begin
      put_char(c, 1'b0);
    end
  endfunction

  function automatic void split_line(input logic k, input logic [UNIT_W-1:0] raw);
    logic [UNIT_W-1:0] c;
    logic [UNIT_W-1:0] cr_u;
    logic [UNIT_W-1:0] lf_u;
    bit is_cr;
    bit is_lf;
    c     = raw & unit_mask();
    cr_u  = {24'd0, CR_CODE} << eol_shift();
    lf_u  = {24'd0, LF_CODE} << eol_shift();
    is_cr = (c == cr_u);
    is_lf = (c == lf_u);
    step_q.delete();
    if (k) begin
      case (eol)
        EOL_NONE: if (held_n != 0) put_char(held[0], 1'b0);
        EOL_CR, EOL_LF_HELD: put_char(held[0], 1'b1);
        default: begin
          put_char(held[0], 1'b1);
          put_char(held[1], 1'b1);
        end
      endcase
      eol    = EOL_NONE;
      held_n = 2'd0;
      return;
    end
    case (eol)
      EOL_NONE, EOL_LF_HELD: begin
        if (held_n != 0) put_char(held[0], eol == EOL_LF_HELD);
        held_n = 2'd0;
        eol    = EOL_NONE;
        take_fresh(c, is_cr, is_lf);
      end
      EOL_CR: begin
        if (is_lf) begin
          put_char(held[0], 1'b0);
          put_char(c, 1'b1);
          held_n = 2'd0;
          eol    = EOL_NONE;
        end else if (is_cr) begin
          held[1] = c;
          held_n  = 2'd2;
          eol     = EOL_CRCR;
        end else begin
          put_char(held[0], 1'b1);
          held_n = 2'd0;
          eol    = EOL_NONE;
          take_fresh(c, 1'b0, 1'b0);
        end
      end
      default: begin
        held_n = 2'd1;
        if (is_lf) begin
          put_char(held[0], 1'b0);
          put_char(held[1], 1'b0);
          eol = EOL_LF_HELD;
        end else begin
          put_char(held[0], 1'b1);
          put_char(held[1], 1'b1);
          eol = is_cr ? EOL_CR : EOL_NONE;
        end
        held[0] = c;
      end
    endcase
  endfunction

  // all handshakes observed here, so prediction always precedes the check
  always @(posedge clk) begin
    result_t want;
    cyc++;
    if (cyc > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cyc);
      $display("text_line_splitter_tb: done, errors");
      $finish;
    end
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.reg_idx)
          REG_CHAR_BYTES: cb_reg = cfg_ch.data[2:0];
          REG_BIG_ENDIAN: be_reg = cfg_ch.data[0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        split_line(in_ch.kind, in_ch.char_value);
        if (use_typed) begin
          foreach (typed_q[i]) line_q.push_back(typed_q[i]);
        end else begin
          foreach (step_q[i]) line_q.push_back(step_q[i]);
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        if (line_q.size() == 0) begin
          report($sformatf("unexpected item char=%h last=%b",
                           out_ch.out_char, out_ch.line_last));
        end else begin
          want = line_q.pop_front();
          if (out_ch.out_char !== want.out_char)
            report($sformatf("out_char %h, want %h", out_ch.out_char, want.out_char));
          if (out_ch.line_last !== want.line_last)
            report($sformatf("line_last %b, want %b (char %h)",
                             out_ch.line_last, want.line_last, want.out_char));
        end
      end
    end
  end

  // result side: a fresh stall draw for every item
  initial begin
    int unsigned stall;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      stall = $urandom_range(0, recv_max);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  task automatic send_item(input logic k, input logic [UNIT_W-1:0] v);
    int unsigned gap;
    gap = $urandom_range(0, gap_max);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.kind       <= k;
    in_ch.char_value <= v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // hold the sender until the block owes nothing, then let held work settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (line_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] d);
    cfg_ch.valid   <= 1'b1;
    cfg_ch.reg_idx <= idx;
    cfg_ch.data    <= d;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  // mostly text with CR/LF at the right byte, plus misplaced codes and flushes
  task automatic pick_char(output logic k, output logic [UNIT_W-1:0] v);
    int unsigned sel;
    logic [UNIT_W-1:0] junk;
    sel  = $urandom_range(0, 99);
    junk = ($urandom_range(0, 1) != 0) ? ($urandom & ~unit_mask()) : '0;
    k    = 1'b0;
    if (sel < 25) begin
      v = ({24'd0, CR_CODE} << eol_shift()) | junk;
    end else if (sel < 45) begin
      v = ({24'd0, LF_CODE} << eol_shift()) | junk;
    end else if (sel < 52) begin
      v = ($urandom_range(0, 1) != 0) ? {24'd0, CR_CODE} : {24'd0, LF_CODE};
      v = v << (8 * $urandom_range(0, 3));
    end else if (sel < 58) begin
      k = 1'b1;
      v = $urandom;
    end else begin
      v = $urandom;
      if ($urandom_range(0, 1) != 0) v = v & unit_mask();
    end
  endtask

  initial begin
    logic              k;
    logic [UNIT_W-1:0] v;
    int unsigned       mode;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.kind       = 1'b0;
    in_ch.char_value = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.reg_idx   = REG_CHAR_BYTES;
    cfg_ch.data      = '0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    gap_max  = 2;
    recv_max = 4;
    foreach (dir_tab[i]) begin
      if (dir_tab[i].op == ROW_CFG) begin
        drain();
        write_reg(dir_tab[i].idx, dir_tab[i].val);
      end else begin
        typed_q.delete();
        if (dir_tab[i].n > 0) typed_q.push_back('{dir_tab[i].c0, dir_tab[i].l0});
        if (dir_tab[i].n > 1) typed_q.push_back('{dir_tab[i].c1, dir_tab[i].l1});
        use_typed = (dir_tab[i].n >= 0);
        send_item(dir_tab[i].op == ROW_FLUSH, dir_tab[i].val);
      end
    end
    use_typed = 1'b0;

    for (int p = 0; p < N_PHASE; p++) begin
      drain();
      mode     = p % 4;
      gap_max  = (mode == 1 || mode == 2) ? 0 : 19;
      recv_max = (mode == 2 || mode == 3) ? 0 : 19;
      write_reg(REG_CHAR_BYTES, {29'($urandom), PH_CB[p]});
      write_reg(REG_BIG_ENDIAN, {31'($urandom), PH_BE[p]});
      if ($urandom_range(0, 1) != 0)
        write_reg(($urandom_range(0, 1) != 0) ? REG_SPARE_LO : REG_SPARE_HI, $urandom);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 149) == 0) drain();
        pick_char(k, v);
        send_item(k, v);
      end
    end
    drain();

    if (line_q.size() != 0)
      report($sformatf("%0d items never arrived", line_q.size()));
    if (err_cnt == 0) begin
      $display("text_line_splitter_tb: done, clean");
    end else begin
      $display("text_line_splitter_tb: done, errors");
    end
    $finish;
  end

endmodule
